>>> src/osr_pkg.sv
// ----------------------------------------------------------------------------
// osr_pkg: shared types and constants of the shooting residual block
// field layouts, register limits and sequencer codes
// ----------------------------------------------------------------------------
package osr_pkg;

	localparam int unsigned STEPS_W   = 13;
	localparam int unsigned STEPS_MIN = 2;
	localparam int unsigned STEPS_MAX = 4096;
	localparam int unsigned STEPS_RST = 2048;
	localparam int unsigned ADDR_W    = 3;
	localparam int unsigned K_W       = 12;
	localparam int unsigned NSQ_W     = 25;
	localparam int unsigned DIV_W     = 39;
	localparam int unsigned SCL_W     = 13;
	localparam int unsigned RES_W     = 47;

	typedef struct packed {
		logic [46:0]        reynolds;
		logic signed [47:0] wavenumber;
		logic signed [47:0] omega_real;
		logic signed [47:0] omega_imag;
	} operands_t;

	typedef struct packed {
		logic [46:0] residual;
		logic        overflow;
	} result_t;

	typedef enum logic [1:0] {
		MD_MULQ,
		MD_SCALE,
		MD_RAW
	} mdu_mode_t;

	typedef struct packed {
		mdu_mode_t mode;
		logic      flip;
	} mdu_ctl_t;

	typedef enum logic [1:0] {
		MS_IDLE,
		MS_MUL,
		MS_DIV,
		MS_FIN
	} mdu_state_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_RUN,
		SQ_FIN
	} sq_state_t;

	typedef enum logic [2:0] {
		TS_IDLE,
		TS_ISSUE,
		TS_WAIT,
		TS_ROOT,
		TS_ROOT_WAIT,
		TS_DONE
	} top_state_t;

	typedef enum logic [4:0] {
		OP_NSQ,
		OP_ARE0,
		OP_ARE1,
		OP_AIM0,
		OP_AIM1,
		OP_BIM,
		OP_GC0,
		OP_GC1,
		OP_PR0,
		OP_PR1,
		OP_PI0,
		OP_PI1,
		OP_QR,
		OP_QI,
		OP_GR0,
		OP_GR1,
		OP_GR2,
		OP_GR3,
		OP_GI0,
		OP_GI1,
		OP_GI2,
		OP_GI3,
		OP_SQ0,
		OP_SQ1
	} op_t;

	typedef enum logic [3:0] {
		D_NONE,
		D_ARE,
		D_AIM,
		D_BIM,
		D_GCR,
		D_GCI,
		D_PR,
		D_PI,
		D_QR,
		D_QI,
		D_GR,
		D_GI,
		D_NSQ,
		D_SQ
	} dst_t;

	typedef enum logic [1:0] {
		WB_LD,
		WB_NEG,
		WB_ADD,
		WB_SUB
	} wb_t;

endpackage

>>> src/osr_mdu.sv
// ----------------------------------------------------------------------------
// osr_mdu: shared multiply / scale unit
// shift-add product, given out raw or followed by fixed-point rounding or
// restoring division; those two round half away from zero and saturate to the word
// ----------------------------------------------------------------------------
module osr_mdu #(
	parameter int unsigned W = 48,
	parameter int unsigned F = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  osr_pkg::mdu_ctl_t          ctl,
	input  logic [W-1:0]               x,
	input  logic [W-1:0]               m,
	input  logic [osr_pkg::DIV_W-1:0]  d,
	output logic                       done,
	output logic [W-1:0]               res,
	output logic [2*W-1:0]             prod,
	output logic                       ovf
);

	localparam int unsigned PW = 2 * W;
	localparam int unsigned SB = W + osr_pkg::SCL_W;
	localparam int unsigned CW = $clog2(SB + 1);
	localparam int unsigned DW = osr_pkg::DIV_W;
	localparam logic [PW:0] WMAX_E = {{(PW + 2 - W){1'b0}}, {(W - 1){1'b1}}};

	osr_pkg::mdu_state_t state_q, state_d;
	osr_pkg::mdu_mode_t  mode_q;
	logic                neg_q;
	logic [PW-1:0]       mcand_q;
	logic [W-1:0]        mplier_q;
	logic [PW-1:0]       prod_q;
	logic [DW-1:0]       d_q;
	logic [SB-1:0]       div_q;
	logic [SB-1:0]       quo_q;
	logic [DW-1:0]       rem_q;
	logic [CW-1:0]       cnt_q;

	logic [W-1:0]        xmag;
	logic [DW:0]         trial;
	logic [DW:0]         diff;
	logic                ge;
	logic [PW:0]         qsel;
	logic                rnd;

	assign xmag  = x[W-1] ? (~x + 1'b1) : x;
	assign trial = {rem_q, div_q[SB-1]};
	assign diff  = trial - {1'b0, d_q};
	assign ge    = trial >= {1'b0, d_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			osr_pkg::MS_IDLE: begin
				if (start) state_d = osr_pkg::MS_MUL;
			end
			osr_pkg::MS_MUL: begin
				if (mplier_q == '0) begin
					state_d = (mode_q == osr_pkg::MD_SCALE) ? osr_pkg::MS_DIV : osr_pkg::MS_FIN;
				end
			end
			osr_pkg::MS_DIV: begin
				if (cnt_q == CW'(SB - 1)) state_d = osr_pkg::MS_FIN;
			end
			osr_pkg::MS_FIN: state_d = osr_pkg::MS_IDLE;
			default: state_d = osr_pkg::MS_IDLE;
		endcase
	end

	// rounding and saturation of the finished product or quotient
	always_comb begin
		rnd  = 1'b0;
		qsel = '0;
		res  = '0;
		ovf  = 1'b0;
		done = (state_q == osr_pkg::MS_FIN);
		case (mode_q)
			osr_pkg::MD_MULQ: begin
				rnd  = prod_q[F-1];
				qsel = {1'b0, prod_q >> F} + {{PW{1'b0}}, rnd};
			end
			osr_pkg::MD_SCALE: begin
				rnd  = {rem_q, 1'b0} >= {1'b0, d_q};
				qsel = {{(PW + 1 - SB){1'b0}}, quo_q} + {{PW{1'b0}}, rnd};
			end
			default: qsel = '0;
		endcase
		if (mode_q != osr_pkg::MD_RAW) begin
			if (!neg_q) begin
				if (qsel > WMAX_E) begin
					ovf = 1'b1;
					res = {1'b0, {(W - 1){1'b1}}};
				end else begin
					res = qsel[W-1:0];
				end
			end else begin
				if (qsel > WMAX_E + 1'b1) begin
					ovf = 1'b1;
					res = {1'b1, {(W - 1){1'b0}}};
				end else begin
					res = ~qsel[W-1:0] + 1'b1;
				end
			end
		end
	end

	assign prod = prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= osr_pkg::MS_IDLE;
			mode_q  <= osr_pkg::MD_MULQ;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				osr_pkg::MS_IDLE: begin
					if (start) begin
						mode_q   <= ctl.mode;
						neg_q    <= x[W-1] ^ ctl.flip;
						mcand_q  <= {{W{1'b0}}, xmag};
						mplier_q <= m;
						prod_q   <= '0;
						d_q      <= d;
					end
				end
				osr_pkg::MS_MUL: begin
					if (mplier_q != '0) begin
						prod_q   <= prod_q + (mplier_q[0] ? mcand_q : '0);
						mcand_q  <= mcand_q << 1;
						mplier_q <= mplier_q >> 1;
					end else begin
						div_q <= prod_q[SB-1:0];
						quo_q <= '0;
						rem_q <= '0;
						cnt_q <= '0;
					end
				end
				osr_pkg::MS_DIV: begin
					rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
					quo_q <= {quo_q[SB-2:0], ge};
					div_q <= div_q << 1;
					cnt_q <= cnt_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

>>> src/osr_isqrt.sv
// ----------------------------------------------------------------------------
// osr_isqrt: digit-recurrence integer square root
// two radicand bits per cycle, floor of the root
// ----------------------------------------------------------------------------
module osr_isqrt #(
	parameter int unsigned W = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [2*W-1:0]   radicand,
	output logic             done,
	output logic [W-1:0]     root
);

	localparam int unsigned CW = $clog2(W + 1);

	osr_pkg::sq_state_t state_q, state_d;
	logic [2*W-1:0]     rad_q;
	logic [W+1:0]       rem_q;
	logic [W-1:0]       root_q;
	logic [CW-1:0]      cnt_q;

	logic [W+3:0]       trem;
	logic [W+3:0]       tsub;
	logic [W+3:0]       tdiff;
	logic               ge;

	assign trem  = {rem_q, rad_q[2*W-1:2*W-2]};
	assign tsub  = {2'b00, root_q, 2'b01};
	assign tdiff = trem - tsub;
	assign ge    = trem >= tsub;

	always_comb begin
		state_d = state_q;
		case (state_q)
			osr_pkg::SQ_IDLE: begin
				if (start) state_d = osr_pkg::SQ_RUN;
			end
			osr_pkg::SQ_RUN: begin
				if (cnt_q == CW'(W - 1)) state_d = osr_pkg::SQ_FIN;
			end
			osr_pkg::SQ_FIN: state_d = osr_pkg::SQ_IDLE;
			default: state_d = osr_pkg::SQ_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == osr_pkg::SQ_FIN);
		root = root_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= osr_pkg::SQ_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				osr_pkg::SQ_IDLE: begin
					if (start) begin
						rad_q  <= radicand;
						rem_q  <= '0;
						root_q <= '0;
						cnt_q  <= '0;
					end
				end
				osr_pkg::SQ_RUN: begin
					rem_q  <= ge ? tdiff[W+1:0] : trem[W+1:0];
					root_q <= {root_q[W-2:0], ge};
					rad_q  <= rad_q << 2;
					cnt_q  <= cnt_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

>>> src/ode_shooting_residual.sv
// ----------------------------------------------------------------------------
// ode_shooting_residual: shooting residual of a transformed stability equation
// forms a, b from the inputs, runs the three-term complex recurrence over
// steps-1 steps and returns the saturated magnitude of the last value
// ----------------------------------------------------------------------------
//
// channel   ports                                   transfer
// -------   -------------------------------------   ---------------------------
// command   start, busy, operands                   start high while busy low
// result    done, result                            done high, one cycle
// config    psel, penable, pwrite, paddr, pwdata,   psel & penable & pwrite
//           prdata, pready
//
// one item runs as a list of operations on the shared multiply / scale unit:
// eight setup operations, fourteen per recurrence step, two squares, then the
// root. a product runs the issue, a shift-add over the multiplier bits, a
// check that the multiplier is empty and the done state; a rational scaling
// adds a division after a product of at most 13 multiplier bits, one quotient
// bit a cycle over W+13 bits. busy stays high from the accepted start until
// the done cycle; done cannot be stalled, and the result register holds its
// value until the root of the next item is done.
// reset clears control state and sets steps to 2048.
//
module ode_shooting_residual #(
	parameter int unsigned WORD_BITS = 48,
	parameter int unsigned FRAC_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [osr_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        start,
	input  osr_pkg::operands_t          operands,
	output logic                        busy,
	output logic                        done,
	output osr_pkg::result_t            result
);

	localparam int unsigned W  = WORD_BITS;
	localparam int unsigned DW = osr_pkg::DIV_W;
	localparam logic [W-1:0] WMAX = {1'b0, {(W - 1){1'b1}}};
	localparam logic [W-1:0] WMIN = {1'b1, {(W - 1){1'b0}}};
	localparam logic signed [65:0] WMAX_E = (66'sd1 <<< (W - 1)) - 66'sd1;
	localparam logic signed [65:0] WMIN_E = -WMAX_E - 66'sd1;
	localparam logic signed [65:0] ONE_E  = 66'sd1 <<< FRAC_BITS;
	localparam logic [64:0] WMAX_U = (65'd1 << (W - 1)) - 65'd1;
	localparam logic [64:0] RES_MAX = {18'd0, {osr_pkg::RES_W{1'b1}}};
	localparam logic [64:0] LIM = (WMAX_U < RES_MAX) ? WMAX_U : RES_MAX;

	// clamp a wide signed value into the word, flag in the top bit
	function automatic logic [W:0] clamp_in(input logic signed [65:0] v);
		if (v > WMAX_E) return {1'b1, WMAX};
		if (v < WMIN_E) return {1'b1, WMIN};
		return {1'b0, v[W-1:0]};
	endfunction

	function automatic logic [W-1:0] mag_w(input logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [W-1:0] scl_w(input logic [osr_pkg::SCL_W-1:0] v);
		return {{(W - osr_pkg::SCL_W){1'b0}}, v};
	endfunction

	// configuration register
	logic [osr_pkg::STEPS_W-1:0] steps_q;
	logic                        reg_hit;
	logic [osr_pkg::STEPS_W-1:0] wr_steps;

	assign reg_hit = (paddr[osr_pkg::ADDR_W-1:2] == '0);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? {{(32 - osr_pkg::STEPS_W){1'b0}}, steps_q} : 32'd0;

	always_comb begin
		wr_steps = pwdata[osr_pkg::STEPS_W-1:0];
		if (wr_steps < osr_pkg::STEPS_W'(osr_pkg::STEPS_MIN))
			wr_steps = osr_pkg::STEPS_W'(osr_pkg::STEPS_MIN);
		if (wr_steps > osr_pkg::STEPS_W'(osr_pkg::STEPS_MAX))
			wr_steps = osr_pkg::STEPS_W'(osr_pkg::STEPS_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= osr_pkg::STEPS_W'(osr_pkg::STEPS_RST);
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			steps_q <= wr_steps;
		end
	end

	// working registers
	osr_pkg::top_state_t state_q, state_d;
	osr_pkg::op_t        pc_q;
	logic [W-1:0] rey_q, kz_q, wr_q, wi_q;
	logic [W-1:0] are_q, aim_q, bim_q;
	logic [W-1:0] gpr_q, gpi_q, gcr_q, gci_q;
	logic [W-1:0] pr_q, pi_q, qr_q, qi_q, gr_q, gi_q;
	logic [2*W-1:0]               sq_q;
	logic [osr_pkg::STEPS_W-1:0]  n_q;
	logic [osr_pkg::NSQ_W-1:0]    nsq_q;
	logic [osr_pkg::K_W-1:0]      k_q;
	logic [osr_pkg::STEPS_W-1:0]  k1_q;
	logic [DW-1:0]                d1_q, d2_q;
	logic                         ovf_q;
	osr_pkg::result_t             res_q;

	// input clamps at the transfer
	logic [W:0] c_rey, c_kz, c_wr, c_wi, c_one;

	assign c_rey = clamp_in($signed({19'd0, operands.reynolds}));
	assign c_kz  = clamp_in($signed({{18{operands.wavenumber[47]}}, operands.wavenumber}));
	assign c_wr  = clamp_in($signed({{18{operands.omega_real[47]}}, operands.omega_real}));
	assign c_wi  = clamp_in($signed({{18{operands.omega_imag[47]}}, operands.omega_imag}));
	assign c_one = clamp_in(ONE_E);

	// shared unit
	logic                  mdu_start, mdu_done, mdu_ovf;
	osr_pkg::mdu_ctl_t     op_ctl;
	logic [W-1:0]          op_x, op_m, mdu_res;
	logic [DW-1:0]         op_d;
	logic [2*W-1:0]        mdu_prod;
	osr_pkg::dst_t         op_dst;
	osr_pkg::wb_t          op_wb;

	osr_mdu #(.W(W), .F(FRAC_BITS)) u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mdu_start),
		.ctl    (op_ctl),
		.x      (op_x),
		.m      (op_m),
		.d      (op_d),
		.done   (mdu_done),
		.res    (mdu_res),
		.prod   (mdu_prod),
		.ovf    (mdu_ovf)
	);

	logic           sqrt_start, sqrt_done;
	logic [W-1:0]   sqrt_root;

	osr_isqrt #(.W(W)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sq_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// operation decode: mulq(x, y) feeds |y| as multiplier with y's sign as flip
	always_comb begin
		op_ctl = '{mode: osr_pkg::MD_MULQ, flip: 1'b0};
		op_x   = '0;
		op_m   = '0;
		op_d   = d1_q;
		op_dst = osr_pkg::D_NONE;
		op_wb  = osr_pkg::WB_LD;
		case (pc_q)
			osr_pkg::OP_NSQ: begin
				op_ctl.mode = osr_pkg::MD_RAW;
				op_x   = {{(W - osr_pkg::STEPS_W){1'b0}}, n_q};
				op_m   = {{(W - osr_pkg::STEPS_W){1'b0}}, n_q};
				op_dst = osr_pkg::D_NSQ;
			end
			osr_pkg::OP_ARE0: begin
				op_x = kz_q; op_m = mag_w(kz_q); op_ctl.flip = kz_q[W-1];
				op_dst = osr_pkg::D_ARE; op_wb = osr_pkg::WB_NEG;
			end
			osr_pkg::OP_ARE1: begin
				op_x = rey_q; op_m = mag_w(wi_q); op_ctl.flip = wi_q[W-1];
				op_dst = osr_pkg::D_ARE; op_wb = osr_pkg::WB_SUB;
			end
			osr_pkg::OP_AIM0: begin
				op_x = rey_q; op_m = mag_w(wr_q); op_ctl.flip = wr_q[W-1];
				op_dst = osr_pkg::D_AIM; op_wb = osr_pkg::WB_LD;
			end
			osr_pkg::OP_AIM1: begin
				op_x = rey_q; op_m = mag_w(kz_q); op_ctl.flip = kz_q[W-1];
				op_dst = osr_pkg::D_AIM; op_wb = osr_pkg::WB_SUB;
			end
			osr_pkg::OP_BIM: begin
				op_x = kz_q; op_m = mag_w(rey_q); op_ctl.flip = rey_q[W-1];
				op_dst = osr_pkg::D_BIM; op_wb = osr_pkg::WB_LD;
			end
			// first step: g1 = 1 - a*h/8
			osr_pkg::OP_GC0: begin
				op_ctl.mode = osr_pkg::MD_SCALE;
				op_x = are_q; op_m = scl_w(osr_pkg::SCL_W'(1));
				op_dst = osr_pkg::D_GCR; op_wb = osr_pkg::WB_SUB;
			end
			osr_pkg::OP_GC1: begin
				op_ctl.mode = osr_pkg::MD_SCALE;
				op_x = aim_q; op_m = scl_w(osr_pkg::SCL_W'(1));
				op_dst = osr_pkg::D_GCI; op_wb = osr_pkg::WB_NEG;
			end
			// p = a * g(k)
			osr_pkg::OP_PR0: begin
				op_x = are_q; op_m = mag_w(gcr_q); op_ctl.flip = gcr_q[W-1];
				op_dst = osr_pkg::D_PR; op_wb = osr_pkg::WB_LD;
			end
			osr_pkg::OP_PR1: begin
				op_x = aim_q; op_m = mag_w(gci_q); op_ctl.flip = gci_q[W-1];
				op_dst = osr_pkg::D_PR; op_wb = osr_pkg::WB_SUB;
			end
			osr_pkg::OP_PI0: begin
				op_x = are_q; op_m = mag_w(gci_q); op_ctl.flip = gci_q[W-1];
				op_dst = osr_pkg::D_PI; op_wb = osr_pkg::WB_LD;
			end
			osr_pkg::OP_PI1: begin
				op_x = aim_q; op_m = mag_w(gcr_q); op_ctl.flip = gcr_q[W-1];
				op_dst = osr_pkg::D_PI; op_wb = osr_pkg::WB_ADD;
			end
			// q = i*b * g(k)
			osr_pkg::OP_QR: begin
				op_x = bim_q; op_m = mag_w(gci_q); op_ctl.flip = gci_q[W-1];
				op_dst = osr_pkg::D_QR; op_wb = osr_pkg::WB_NEG;
			end
			osr_pkg::OP_QI: begin
				op_x = bim_q; op_m = mag_w(gcr_q); op_ctl.flip = gcr_q[W-1];
				op_dst = osr_pkg::D_QI; op_wb = osr_pkg::WB_LD;
			end
			// next value, real then imaginary, four rounded terms each
			osr_pkg::OP_GR0, osr_pkg::OP_GI0: begin
				op_ctl = '{mode: osr_pkg::MD_SCALE, flip: 1'b1};
				op_x = (pc_q == osr_pkg::OP_GR0) ? gpr_q : gpi_q;
				op_m = scl_w(osr_pkg::SCL_W'(k_q - 1'b1));
				op_d = {{(DW - osr_pkg::STEPS_W){1'b0}}, k1_q};
				op_dst = (pc_q == osr_pkg::OP_GR0) ? osr_pkg::D_GR : osr_pkg::D_GI;
				op_wb = osr_pkg::WB_LD;
			end
			osr_pkg::OP_GR1, osr_pkg::OP_GI1: begin
				op_ctl.mode = osr_pkg::MD_SCALE;
				op_x = (pc_q == osr_pkg::OP_GR1) ? gcr_q : gci_q;
				op_m = scl_w({k_q, 1'b0});
				op_d = {{(DW - osr_pkg::STEPS_W){1'b0}}, k1_q};
				op_dst = (pc_q == osr_pkg::OP_GR1) ? osr_pkg::D_GR : osr_pkg::D_GI;
				op_wb = osr_pkg::WB_ADD;
			end
			osr_pkg::OP_GR2, osr_pkg::OP_GI2: begin
				op_ctl.mode = osr_pkg::MD_SCALE;
				op_x = (pc_q == osr_pkg::OP_GR2) ? pr_q : pi_q;
				op_m = scl_w(osr_pkg::SCL_W'(1));
				op_d = d1_q;
				op_dst = (pc_q == osr_pkg::OP_GR2) ? osr_pkg::D_GR : osr_pkg::D_GI;
				op_wb = osr_pkg::WB_SUB;
			end
			osr_pkg::OP_GR3, osr_pkg::OP_GI3: begin
				op_ctl.mode = osr_pkg::MD_SCALE;
				op_x = (pc_q == osr_pkg::OP_GR3) ? qr_q : qi_q;
				op_m = scl_w({1'b0, k_q});
				op_d = d2_q;
				op_dst = (pc_q == osr_pkg::OP_GR3) ? osr_pkg::D_GR : osr_pkg::D_GI;
				op_wb = osr_pkg::WB_SUB;
			end
			// squared magnitude of the final value
			osr_pkg::OP_SQ0: begin
				op_ctl.mode = osr_pkg::MD_RAW;
				op_x = gcr_q; op_m = mag_w(gcr_q);
				op_dst = osr_pkg::D_SQ; op_wb = osr_pkg::WB_LD;
			end
			osr_pkg::OP_SQ1: begin
				op_ctl.mode = osr_pkg::MD_RAW;
				op_x = gci_q; op_m = mag_w(gci_q);
				op_dst = osr_pkg::D_SQ; op_wb = osr_pkg::WB_ADD;
			end
			default: op_dst = osr_pkg::D_NONE;
		endcase
	end

	// write-back with saturating accumulate
	logic [W-1:0]        wb_cur;
	logic signed [W:0]   wb_sum;
	logic [W-1:0]        wb_val;
	logic                wb_ovf;

	always_comb begin
		case (op_dst)
			osr_pkg::D_ARE: wb_cur = are_q;
			osr_pkg::D_AIM: wb_cur = aim_q;
			osr_pkg::D_GCR: wb_cur = gcr_q;
			osr_pkg::D_GCI: wb_cur = gci_q;
			osr_pkg::D_PR:  wb_cur = pr_q;
			osr_pkg::D_PI:  wb_cur = pi_q;
			osr_pkg::D_GR:  wb_cur = gr_q;
			osr_pkg::D_GI:  wb_cur = gi_q;
			default:        wb_cur = '0;
		endcase
		case (op_wb)
			osr_pkg::WB_LD:  wb_sum = $signed({mdu_res[W-1], mdu_res});
			osr_pkg::WB_NEG: wb_sum = -$signed({mdu_res[W-1], mdu_res});
			osr_pkg::WB_ADD: wb_sum = $signed({wb_cur[W-1], wb_cur})
			                        + $signed({mdu_res[W-1], mdu_res});
			osr_pkg::WB_SUB: wb_sum = $signed({wb_cur[W-1], wb_cur})
			                        - $signed({mdu_res[W-1], mdu_res});
			default:         wb_sum = $signed({mdu_res[W-1], mdu_res});
		endcase
		wb_ovf = (wb_sum[W] != wb_sum[W-1]);
		wb_val = wb_ovf ? (wb_sum[W] ? WMIN : WMAX) : wb_sum[W-1:0];
	end

	logic last_k;
	assign last_k = ({1'b0, k_q} == n_q - 1'b1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			osr_pkg::TS_IDLE: begin
				if (start) state_d = osr_pkg::TS_ISSUE;
			end
			osr_pkg::TS_ISSUE: state_d = osr_pkg::TS_WAIT;
			osr_pkg::TS_WAIT: begin
				if (mdu_done)
					state_d = (pc_q == osr_pkg::OP_SQ1) ? osr_pkg::TS_ROOT : osr_pkg::TS_ISSUE;
			end
			osr_pkg::TS_ROOT: state_d = osr_pkg::TS_ROOT_WAIT;
			osr_pkg::TS_ROOT_WAIT: begin
				if (sqrt_done) state_d = osr_pkg::TS_DONE;
			end
			osr_pkg::TS_DONE: state_d = osr_pkg::TS_IDLE;
			default: state_d = osr_pkg::TS_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy       = (state_q != osr_pkg::TS_IDLE);
		mdu_start  = (state_q == osr_pkg::TS_ISSUE);
		sqrt_start = (state_q == osr_pkg::TS_ROOT);
		done       = (state_q == osr_pkg::TS_DONE);
		result     = res_q;
	end

	logic [64:0] root_u;
	assign root_u = {{(65 - W){1'b0}}, sqrt_root};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= osr_pkg::TS_IDLE;
			pc_q    <= osr_pkg::OP_NSQ;
			ovf_q   <= 1'b0;
			k_q     <= '0;
			k1_q    <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				osr_pkg::TS_IDLE: begin
					if (start) begin
						rey_q <= c_rey[W-1:0];
						kz_q  <= c_kz[W-1:0];
						wr_q  <= c_wr[W-1:0];
						wi_q  <= c_wi[W-1:0];
						gpr_q <= c_one[W-1:0];
						gcr_q <= c_one[W-1:0];
						gpi_q <= '0;
						gci_q <= '0;
						ovf_q <= c_rey[W] | c_kz[W] | c_wr[W] | c_wi[W] | c_one[W];
						n_q   <= steps_q;
						d1_q  <= DW'({steps_q, 3'b000});
						k_q   <= osr_pkg::K_W'(1);
						k1_q  <= osr_pkg::STEPS_W'(2);
						pc_q  <= osr_pkg::OP_NSQ;
					end
				end
				osr_pkg::TS_WAIT: begin
					if (mdu_done) begin
						ovf_q <= ovf_q | mdu_ovf | wb_ovf;
						case (op_dst)
							osr_pkg::D_ARE: are_q <= wb_val;
							osr_pkg::D_AIM: aim_q <= wb_val;
							osr_pkg::D_BIM: bim_q <= wb_val;
							osr_pkg::D_GCR: gcr_q <= wb_val;
							osr_pkg::D_GCI: gci_q <= wb_val;
							osr_pkg::D_PR:  pr_q  <= wb_val;
							osr_pkg::D_PI:  pi_q  <= wb_val;
							osr_pkg::D_QR:  qr_q  <= wb_val;
							osr_pkg::D_QI:  qi_q  <= wb_val;
							osr_pkg::D_GR:  gr_q  <= wb_val;
							osr_pkg::D_GI: begin
								if (pc_q == osr_pkg::OP_GI3) begin
									// end of step: shift the recurrence window
									gpr_q <= gcr_q;
									gpi_q <= gci_q;
									gcr_q <= gr_q;
									gci_q <= wb_val;
								end else begin
									gi_q <= wb_val;
								end
							end
							osr_pkg::D_NSQ: begin
								nsq_q <= mdu_prod[osr_pkg::NSQ_W-1:0];
								d2_q  <= DW'({mdu_prod[osr_pkg::NSQ_W-1:0], 3'b000});
							end
							osr_pkg::D_SQ: begin
								sq_q <= (op_wb == osr_pkg::WB_ADD) ? (sq_q + mdu_prod) : mdu_prod;
							end
							default: ;
						endcase
						if (pc_q == osr_pkg::OP_GI3) begin
							if (last_k) begin
								pc_q <= osr_pkg::OP_SQ0;
							end else begin
								pc_q <= osr_pkg::OP_PR0;
								k_q  <= k_q + 1'b1;
								k1_q <= k1_q + 1'b1;
								d1_q <= d1_q + DW'({n_q, 2'b00});
								d2_q <= d2_q + DW'({nsq_q, 2'b00});
							end
						end else if (pc_q != osr_pkg::OP_SQ1) begin
							pc_q <= osr_pkg::op_t'(pc_q + 1'b1);
						end
					end
				end
				osr_pkg::TS_ROOT_WAIT: begin
					if (sqrt_done) begin
						if (root_u > LIM) begin
							res_q.residual <= LIM[osr_pkg::RES_W-1:0];
							res_q.overflow <= 1'b1;
						end else begin
							res_q.residual <= root_u[osr_pkg::RES_W-1:0];
							res_q.overflow <= ovf_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule
